// ===== design/tbsm_pkg.sv =====
`timescale 1ns / 1ps

package tbsm_pkg;

   localparam int TIME_W            = 25;
   localparam int STIME_W           = TIME_W + 1;
   localparam int SAMPLE_W          = 16;
   localparam int COUNT_W           = 10;
   localparam int SPACING_W         = 16;
   localparam int LEN_W             = 10;
   localparam int POS_W             = 8;
   localparam int CSR_INDEX_W       = 2;
   localparam int CSR_DATA_W        = 16;
   localparam int MAX_BAD_PER_PULSE = 64;
   localparam int RX_ON_DELAY       = 100;

   localparam logic [SAMPLE_W-1:0]  MAX_SAMPLE_NUM = '1;
   localparam logic [COUNT_W-1:0]   MAX_BAD_COUNT  = '1;

   localparam logic [15:0] FIRST_RANGE_LAG_RST = 16'd1200;
   localparam logic [15:0] SAMPLE_SPACING_RST  = 16'd300;
   localparam logic [15:0] PULSE_INCREMENT_RST = 16'd2400;
   localparam logic [9:0]  PULSE_LENGTH_RST    = 10'd300;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FIRST_RANGE_LAG = 2'd0,
      CSR_SAMPLE_SPACING  = 2'd1,
      CSR_PULSE_INCREMENT = 2'd2,
      CSR_PULSE_LENGTH    = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [POS_W-1:0] pulse_position;
      logic             first_of_sequence;
      logic             end_of_sequence;
   } tbsm_req_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] bad_sample;
      logic                bad_valid;
      logic [COUNT_W-1:0]  bad_total;
      logic                last_of_pulse;
      logic                sequence_done;
   } tbsm_rsp_type;

endpackage

// ===== design/transmit_blanking_sample_marker.sv =====
`timescale 1ns / 1ps

// Channel    Direction  Payload                      Handshake
// req_       in         tbsm_req_type (one pulse)    req_valid / req_ready
// rsp_       out        tbsm_rsp_type (one result)   rsp_valid / rsp_ready
// csr_       in         csr_index, csr_data          csr_valid / csr_ready (always ready)
//
// A pulse runs setup in S_CALC and S_PREP, then up to two passes of a shared
// 25-step restoring divider (advance to window start, then window size), then
// one result per cycle while rsp_ is not stalled; one pulse at a time.
// Reset is synchronous; it loads the register defaults and a fresh sequence.
// A stalled rsp_ holds the result register and the block waits to emit more.

module transmit_blanking_sample_marker
   import tbsm_pkg::*;
#(
   parameter int MAX_BAD = MAX_BAD_PER_PULSE
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  tbsm_req_type           req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output tbsm_rsp_type           rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int LEFT_W = $clog2(MAX_BAD + 1);
   localparam int CNT_W  = $clog2(TIME_W);

   typedef enum logic [5:0] {
      S_IDLE = 6'b000001,
      S_CALC = 6'b000010,
      S_PREP = 6'b000100,
      S_DIV  = 6'b001000,
      S_POST = 6'b010000,
      S_EMIT = 6'b100000
   } state_type;

   function automatic logic [SAMPLE_W-1:0] sat_add(input logic [SAMPLE_W-1:0] a,
                                                  input logic [STIME_W-1:0]  b);
      logic [STIME_W:0] s;
      s = (STIME_W+1)'(a) + (STIME_W+1)'(b);
      return (s > (STIME_W+1)'(MAX_SAMPLE_NUM)) ? MAX_SAMPLE_NUM : s[SAMPLE_W-1:0];
   endfunction

   state_type                  state_ff, state_in;
   logic [15:0]                frl_ff, frl_in;
   logic [SPACING_W-1:0]       sp_ff, sp_in;
   logic [15:0]                inc_ff, inc_in;
   logic [LEN_W-1:0]           len_ff, len_in;
   logic [TIME_W-1:0]          stime_ff, stime_in;
   logic [SAMPLE_W-1:0]        snum_ff, snum_in;
   logic [COUNT_W-1:0]         bad_ff, bad_in;
   logic [POS_W-1:0]           pos_ff, pos_in;
   logic                       eos_ff, eos_in;
   logic signed [STIME_W-1:0]  t1_ff, t1_in;
   logic signed [STIME_W-1:0]  t2_ff, t2_in;
   logic                       mode_ff, mode_in;
   logic [TIME_W-1:0]          dvd_ff, dvd_in;
   logic [SPACING_W-1:0]       rem_ff, rem_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic [SAMPLE_W-1:0]        idx_ff, idx_in;
   logic [LEFT_W-1:0]          left_ff, left_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   tbsm_rsp_type               rsp_data_ff, rsp_data_in;

   logic [SPACING_W-1:0]       sp_eff;
   logic signed [STIME_W-1:0]  ts_s;
   logic [23:0]                prod;
   logic [LEN_W+1:0]           len3;
   logic [SPACING_W:0]         trial_hi;
   logic [SPACING_W:0]         trial;
   logic                       rem_nz;
   logic [STIME_W-1:0]         qplus;
   logic                       slot_free;
   logic [COUNT_W-1:0]         bad_next;

   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign sp_eff    = (sp_ff == '0) ? SPACING_W'(1) : sp_ff;
   assign ts_s      = $signed({1'b0, stime_ff});
   assign prod      = 24'(pos_ff) * 24'(inc_ff);
   assign len3      = {2'b00, len_ff} + {1'b0, len_ff, 1'b0};
   assign trial_hi  = {rem_ff, dvd_ff[TIME_W-1]};
   assign trial     = trial_hi - {1'b0, sp_eff};
   assign rem_nz    = (rem_ff != '0);
   assign qplus     = {1'b0, dvd_ff} + STIME_W'(rem_nz);
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign bad_next  = (bad_ff == MAX_BAD_COUNT) ? bad_ff : bad_ff + COUNT_W'(1);

   always_comb begin
      state_in     = state_ff;
      frl_in       = frl_ff;
      sp_in        = sp_ff;
      inc_in       = inc_ff;
      len_in       = len_ff;
      stime_in     = stime_ff;
      snum_in      = snum_ff;
      bad_in       = bad_ff;
      pos_in       = pos_ff;
      eos_in       = eos_ff;
      t1_in        = t1_ff;
      t2_in        = t2_ff;
      mode_in      = mode_ff;
      dvd_in       = dvd_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      left_in      = left_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;

      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_FIRST_RANGE_LAG: frl_in = csr_data;
            CSR_SAMPLE_SPACING:  sp_in  = csr_data;
            CSR_PULSE_INCREMENT: inc_in = csr_data;
            CSR_PULSE_LENGTH:    len_in = csr_data[LEN_W-1:0];
            default:             frl_in = frl_ff;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               pos_in = req_data.pulse_position;
               eos_in = req_data.end_of_sequence;
               if (req_data.first_of_sequence) begin
                  stime_in = TIME_W'(frl_ff);
                  snum_in  = '0;
                  bad_in   = '0;
               end
               state_in = S_CALC;
            end
         end
         S_CALC: begin
            t1_in    = $signed({2'b00, prod}) - $signed(STIME_W'(len_ff[LEN_W-1:1]));
            t2_in    = $signed({2'b00, prod}) - $signed(STIME_W'(len_ff[LEN_W-1:1]))
                       + $signed(STIME_W'(len3[LEN_W+1:1]))
                       + $signed(STIME_W'(RX_ON_DELAY));
            state_in = S_PREP;
         end
         S_PREP: begin
            rem_in = '0;
            cnt_in = '0;
            if (ts_s < t1_ff) begin
               mode_in  = 1'b0;
               dvd_in   = TIME_W'(t1_ff - ts_s);
               state_in = S_DIV;
            end else if (ts_s <= t2_ff) begin
               mode_in  = 1'b1;
               dvd_in   = TIME_W'(t2_ff - ts_s);
               state_in = S_DIV;
            end else begin
               left_in  = '0;
               state_in = S_EMIT;
            end
         end
         S_DIV: begin
            if (trial_hi >= {1'b0, sp_eff}) begin
               rem_in = trial[SPACING_W-1:0];
               dvd_in = {dvd_ff[TIME_W-2:0], 1'b1};
            end else begin
               rem_in = trial_hi[SPACING_W-1:0];
               dvd_in = {dvd_ff[TIME_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(TIME_W - 1)) begin
               state_in = S_POST;
            end
         end
         S_POST: begin
            if (!mode_ff) begin
               stime_in = TIME_W'(t1_ff) + (rem_nz ? TIME_W'(sp_eff - rem_ff) : '0);
               snum_in  = sat_add(snum_ff, qplus);
               state_in = S_PREP;
            end else begin
               stime_in = TIME_W'(t2_ff) + TIME_W'(sp_eff) - TIME_W'(rem_ff);
               snum_in  = sat_add(snum_ff, {1'b0, dvd_ff} + STIME_W'(1));
               idx_in   = snum_ff;
               left_in  = ({1'b0, dvd_ff} + STIME_W'(1) > STIME_W'(MAX_BAD))
                          ? LEFT_W'(MAX_BAD) : LEFT_W'(dvd_ff + TIME_W'(1));
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               if (left_ff == '0) begin
                  rsp_data_in.bad_sample    = '0;
                  rsp_data_in.bad_valid     = 1'b0;
                  rsp_data_in.bad_total     = bad_ff;
                  rsp_data_in.last_of_pulse = 1'b1;
                  rsp_data_in.sequence_done = eos_ff;
                  state_in                  = S_IDLE;
               end else begin
                  bad_in                    = bad_next;
                  rsp_data_in.bad_sample    = idx_ff;
                  rsp_data_in.bad_valid     = 1'b1;
                  rsp_data_in.bad_total     = bad_next;
                  rsp_data_in.last_of_pulse = (left_ff == LEFT_W'(1));
                  rsp_data_in.sequence_done = (left_ff == LEFT_W'(1)) && eos_ff;
                  idx_in  = (idx_ff == MAX_SAMPLE_NUM) ? idx_ff : idx_ff + SAMPLE_W'(1);
                  left_in = left_ff - LEFT_W'(1);
                  if (left_ff == LEFT_W'(1)) begin
                     state_in = S_IDLE;
                  end
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         frl_ff       <= FIRST_RANGE_LAG_RST;
         sp_ff        <= SAMPLE_SPACING_RST;
         inc_ff       <= PULSE_INCREMENT_RST;
         len_ff       <= PULSE_LENGTH_RST;
         stime_ff     <= TIME_W'(FIRST_RANGE_LAG_RST);
         snum_ff      <= '0;
         bad_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         frl_ff       <= frl_in;
         sp_ff        <= sp_in;
         inc_ff       <= inc_in;
         len_ff       <= len_in;
         stime_ff     <= stime_in;
         snum_ff      <= snum_in;
         bad_ff       <= bad_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff      <= pos_in;
      eos_ff      <= eos_in;
      t1_ff       <= t1_in;
      t2_ff       <= t2_in;
      mode_ff     <= mode_in;
      dvd_ff      <= dvd_in;
      rem_ff      <= rem_in;
      cnt_ff      <= cnt_in;
      idx_ff      <= idx_in;
      left_ff     <= left_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// ===== design/tbsm_checker.sv =====
`timescale 1ns / 1ps

module tbsm_checker
   import tbsm_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_ready,
   input logic         rsp_valid,
   input logic         rsp_ready,
   input tbsm_rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_data))
      else $error("result changed while stalled");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while a pulse is in progress");

   a_done_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.sequence_done |-> rsp_data.last_of_pulse)
      else $error("sequence done on a result that is not last of pulse");

   a_empty_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.bad_valid |-> rsp_data.last_of_pulse && rsp_data.bad_sample == '0)
      else $error("empty result not last of pulse");

endmodule

bind transmit_blanking_sample_marker tbsm_checker u_tbsm_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
